>>> design/rmq_pkg.sv
// ============================================================================
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ============================================================================
`default_nettype none

package rmq_pkg;

    localparam int QUAT_W = 18;   // width of a matrix element or quaternion part
    localparam int MAT_N  = 9;    // matrix elements per word
    localparam int AXES   = 4;    // quaternion parts w, x, y, z
    localparam int VAL_W  = 33;   // signed width of an unnormalized part
    localparam int MAG_W  = 31;   // magnitude width, largest part below 2^31
    localparam int SQ_W   = 62;   // square of one magnitude
    localparam int PAIR_W = 63;   // sum of two squares
    localparam int SUM_W  = 64;   // sum of four squares
    localparam int ROOT_W = 32;   // floor square root of the sum
    localparam int REM_W  = 34;   // square root partial remainder

    localparam logic [ROOT_W-1:0] QUAT_POS_MAX = 32'd131071;
    localparam logic [ROOT_W-1:0] QUAT_NEG_MAX = 32'd131072;
    localparam logic [QUAT_W-1:0] QUAT_SAT_HI  = 18'h1FFFF;
    localparam logic [QUAT_W-1:0] QUAT_SAT_LO  = 18'h20000;

    // which part carries the root argument
    typedef enum logic [1:0] {
        PIV_W,
        PIV_X,
        PIV_Y,
        PIV_Z
    } rmq_piv_t;

    typedef struct packed {
        logic [AXES-1:0] neg;
        logic            bad;
    } rmq_tag_t;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] mag;
        rmq_tag_t                   tag;
    } rmq_vec_t;

endpackage

`default_nettype wire

>>> design/rmq_front.sv
// ============================================================================
// rmq_front
// Trace, pivot choice, unnormalized quaternion, then sign and magnitude.
// ============================================================================
`default_nettype none

module rmq_front #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       en,
    input  wire logic                                       in_valid,
    input  wire logic [rmq_pkg::MAT_N-1:0][rmq_pkg::QUAT_W-1:0] mat,
    output logic                                            out_valid,
    output rmq_pkg::rmq_vec_t                               out_vec
);

    localparam logic signed [rmq_pkg::VAL_W-1:0] ONE =
        rmq_pkg::VAL_W'(1) <<< FRACTION_BITS;

    logic signed [rmq_pkg::VAL_W-1:0] mm [rmq_pkg::MAT_N];
    logic signed [rmq_pkg::VAL_W-1:0] tr, arg;
    rmq_pkg::rmq_piv_t                piv;

    logic [rmq_pkg::AXES-1:0][rmq_pkg::VAL_W-1:0] v_next, v_reg;
    logic bad_next, bad_reg, vld1_reg;

    rmq_pkg::rmq_vec_t vec_next, vec_reg;
    logic              vld2_reg;

    always_comb begin
        for (int i = 0; i < rmq_pkg::MAT_N; i++) begin
            mm[i] = rmq_pkg::VAL_W'(signed'(mat[i]));
        end
        tr = mm[0] + mm[4] + mm[8];
        if (tr > 0) begin
            piv = rmq_pkg::PIV_W;
        end else begin
            piv = rmq_pkg::PIV_X;
            if (mm[4] > mm[0]) begin
                piv = rmq_pkg::PIV_Y;
            end
            if (mm[8] > ((piv == rmq_pkg::PIV_Y) ? mm[4] : mm[0])) begin
                piv = rmq_pkg::PIV_Z;
            end
        end
        unique case (piv)
            rmq_pkg::PIV_W: begin
                arg       = tr + ONE;
                v_next[0] = arg;
                v_next[1] = mm[5] - mm[7];
                v_next[2] = mm[6] - mm[2];
                v_next[3] = mm[1] - mm[3];
            end
            rmq_pkg::PIV_X: begin
                arg       = mm[0] - (mm[4] + mm[8]) + ONE;
                v_next[0] = mm[5] - mm[7];
                v_next[1] = arg;
                v_next[2] = mm[1] + mm[3];
                v_next[3] = mm[2] + mm[6];
            end
            rmq_pkg::PIV_Y: begin
                arg       = mm[4] - (mm[8] + mm[0]) + ONE;
                v_next[0] = mm[6] - mm[2];
                v_next[1] = mm[3] + mm[1];
                v_next[2] = arg;
                v_next[3] = mm[5] + mm[7];
            end
            default: begin
                arg       = mm[8] - (mm[0] + mm[4]) + ONE;
                v_next[0] = mm[1] - mm[3];
                v_next[1] = mm[6] + mm[2];
                v_next[2] = mm[7] + mm[5];
                v_next[3] = arg;
            end
        endcase
        bad_next = (arg <= 0);
    end

    always_comb begin
        for (int c = 0; c < rmq_pkg::AXES; c++) begin
            vec_next.tag.neg[c] = v_reg[c][rmq_pkg::VAL_W-1];
            vec_next.mag[c]     = vec_next.tag.neg[c]
                                ? rmq_pkg::MAG_W'(-v_reg[c])
                                : v_reg[c][rmq_pkg::MAG_W-1:0];
        end
        vec_next.tag.bad = bad_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg   <= v_next;
            bad_reg <= bad_next;
            vec_reg <= vec_next;
        end
    end

    assign out_valid = vld2_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

>>> design/rmq_norm_cell.sv
// ============================================================================
// rmq_norm_cell
// One step of the normalizing shift: shifts all magnitudes if room remains.
// ============================================================================
`default_nettype none

module rmq_norm_cell #(
    parameter int SHIFT = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  rmq_pkg::rmq_vec_t  in_vec,
    output logic               out_valid,
    output rmq_pkg::rmq_vec_t  out_vec
);

    logic              any_top;
    rmq_pkg::rmq_vec_t vec_next, vec_reg;
    logic              vld_reg;

    always_comb begin
        any_top  = 1'b0;
        vec_next = in_vec;
        for (int c = 0; c < rmq_pkg::AXES; c++) begin
            any_top = any_top | (|in_vec.mag[c][rmq_pkg::MAG_W-1 -: SHIFT]);
        end
        if (!any_top) begin
            for (int c = 0; c < rmq_pkg::AXES; c++) begin
                vec_next.mag[c] = in_vec.mag[c] << SHIFT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

>>> design/rmq_sqrt_cell.sv
// ============================================================================
// rmq_sqrt_cell
// One root bit of the digit-by-digit square root; magnitudes ride along.
// ============================================================================
`default_nettype none

module rmq_sqrt_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [rmq_pkg::SUM_W-1:0]   in_rad,
    input  wire logic [rmq_pkg::REM_W-1:0]   in_rem,
    input  wire logic [rmq_pkg::ROOT_W-1:0]  in_root,
    input  rmq_pkg::rmq_vec_t                in_vec,
    output logic                             out_valid,
    output logic [rmq_pkg::SUM_W-1:0]        out_rad,
    output logic [rmq_pkg::REM_W-1:0]        out_rem,
    output logic [rmq_pkg::ROOT_W-1:0]       out_root,
    output rmq_pkg::rmq_vec_t                out_vec
);

    localparam int CAT_W = rmq_pkg::REM_W + 2;

    logic [CAT_W-1:0]             cat, trial, diff;
    logic                         ge;
    logic [rmq_pkg::SUM_W-1:0]    rad_next, rad_reg;
    logic [rmq_pkg::REM_W-1:0]    rem_next, rem_reg;
    logic [rmq_pkg::ROOT_W-1:0]   root_next, root_reg;
    rmq_pkg::rmq_vec_t            vec_reg;
    logic                         vld_reg;

    always_comb begin
        cat       = {in_rem, in_rad[rmq_pkg::SUM_W-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        diff      = cat - trial;
        ge        = (cat >= trial);
        rem_next  = ge ? diff[rmq_pkg::REM_W-1:0] : cat[rmq_pkg::REM_W-1:0];
        root_next = {in_root[rmq_pkg::ROOT_W-2:0], ge};
        rad_next  = {in_rad[rmq_pkg::SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            vec_reg  <= in_vec;
        end
    end

    assign out_valid = vld_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

>>> design/rmq_div_cell.sv
// ============================================================================
// rmq_div_cell
// One quotient bit of restoring division, four lanes against a shared norm.
// ============================================================================
`default_nettype none

module rmq_div_cell #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                             aclk,
    input  wire logic                                             aresetn,
    input  wire logic                                             en,
    input  wire logic                                             in_valid,
    input  wire logic [rmq_pkg::AXES-1:0][rmq_pkg::ROOT_W-1:0]    in_rem,
    input  wire logic [rmq_pkg::AXES-1:0][FRACTION_BITS:0]        in_low,
    input  wire logic [rmq_pkg::ROOT_W-1:0]                       in_nrm,
    input  rmq_pkg::rmq_tag_t                                     in_tag,
    output logic                                                  out_valid,
    output logic [rmq_pkg::AXES-1:0][rmq_pkg::ROOT_W-1:0]         out_rem,
    output logic [rmq_pkg::AXES-1:0][FRACTION_BITS:0]             out_low,
    output logic [rmq_pkg::ROOT_W-1:0]                            out_nrm,
    output rmq_pkg::rmq_tag_t                                     out_tag
);

    // low holds dividend bits not yet used; quotient bits shift in behind them
    logic [rmq_pkg::ROOT_W:0]                             t, d;
    logic                                                 ge;
    logic [rmq_pkg::AXES-1:0][rmq_pkg::ROOT_W-1:0]        rem_next, rem_reg;
    logic [rmq_pkg::AXES-1:0][FRACTION_BITS:0]            low_next, low_reg;
    logic [rmq_pkg::ROOT_W-1:0]                           nrm_reg;
    rmq_pkg::rmq_tag_t                                    tag_reg;
    logic                                                 vld_reg;

    always_comb begin
        t  = '0;
        d  = '0;
        ge = 1'b0;
        for (int c = 0; c < rmq_pkg::AXES; c++) begin
            t           = {in_rem[c], in_low[c][FRACTION_BITS]};
            d           = t - {1'b0, in_nrm};
            ge          = (t >= {1'b0, in_nrm});
            rem_next[c] = ge ? d[rmq_pkg::ROOT_W-1:0] : t[rmq_pkg::ROOT_W-1:0];
            low_next[c] = {in_low[c][FRACTION_BITS-1:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            nrm_reg <= in_nrm;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = vld_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_nrm   = nrm_reg;
    assign out_tag   = tag_reg;

endmodule

`default_nettype wire

>>> design/rotation_matrix_to_quaternion.sv
// ============================================================================
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion, Shepperd pivot, fixed-point pipeline.
// ============================================================================
// Usage:
//   s_ channel: one word per 3x3 matrix, nine signed elements m00..m22,
//   FRACTION_BITS fractional bits. m_ channel: one word per matrix, the
//   unit quaternion w, x, y, z plus a bad_input flag in m_tuser.
//   bad_input = 1 marks a non-positive root argument or zero norm; the
//   quaternion is then the identity (w = one unit, saturated).
//   Throughput: one word per cycle unless stalled, words follow back to back.
//   Pipeline order: front end, 5 normalizing shift cells, square, sum,
//   the 32-cell square root row, dividend set-up, the FRACTION_BITS+1 cell
//   divider row and output.
//   Stall: the whole pipeline advances on one enable; when m_tvalid is high
//   and m_tready low, every stage holds and s_tready drops. Nothing is lost.
//   Reset (aresetn low, synchronous): all valid bits clear, the pipeline
//   drains empty; payload registers are not reset.
// ============================================================================
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // s_tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 b each), 6 b zero
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [167:0] s_tdata,
    // m_tdata: quat_w, quat_x, quat_y, quat_z (18 b each)
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,
    // m_tuser: bad_input
    output logic [0:0]        m_tuser
);

    localparam int QW     = rmq_pkg::QUAT_W;
    localparam int NAX    = rmq_pkg::AXES;
    localparam int NSH    = 5;                  // shift cells: 16, 8, 4, 2, 1
    localparam int NSQ    = rmq_pkg::ROOT_W;    // one cell per root bit
    localparam int NDV    = FRACTION_BITS + 1;  // one cell per quotient bit
    localparam int DW     = rmq_pkg::ROOT_W + FRACTION_BITS;
    localparam logic [QW-1:0] ID_W =
        (FRACTION_BITS >= 17) ? rmq_pkg::QUAT_SAT_HI : QW'(1 << FRACTION_BITS);

    logic en;

    // pipeline advances whenever the output register is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------- front
    logic [rmq_pkg::MAT_N-1:0][QW-1:0] mat;
    always_comb begin
        for (int i = 0; i < rmq_pkg::MAT_N; i++) begin
            mat[i] = s_tdata[QW*i +: QW];
        end
    end

    logic              nrm_vld [NSH+1];
    rmq_pkg::rmq_vec_t nrm_vec [NSH+1];

    rmq_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .mat      (mat),
        .out_valid(nrm_vld[0]),
        .out_vec  (nrm_vec[0])
    );

    // ------------------------------------------------ normalizing shift row
    // binary search of the shift that brings the largest magnitude to bit 30
    for (genvar g = 0; g < NSH; g++) begin : g_norm
        rmq_norm_cell #(
            .SHIFT(16 >> g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (nrm_vld[g]),
            .in_vec   (nrm_vec[g]),
            .out_valid(nrm_vld[g+1]),
            .out_vec  (nrm_vec[g+1])
        );
    end

    // ----------------------------------------------------- squares and sum
    logic [NAX-1:0][rmq_pkg::SQ_W-1:0] sq_next, sq_reg;
    logic [1:0][rmq_pkg::PAIR_W-1:0]   pair_reg;
    logic [rmq_pkg::SUM_W-1:0]         sum_reg;
    rmq_pkg::rmq_vec_t                 sqv_reg, pairv_reg, sumv_reg;
    logic                              sqv_vld_reg, pair_vld_reg, sum_vld_reg;

    always_comb begin
        for (int c = 0; c < NAX; c++) begin
            sq_next[c] = rmq_pkg::SQ_W'(nrm_vec[NSH].mag[c])
                       * rmq_pkg::SQ_W'(nrm_vec[NSH].mag[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqv_vld_reg  <= 1'b0;
            pair_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end else if (en) begin
            sqv_vld_reg  <= nrm_vld[NSH];
            pair_vld_reg <= sqv_vld_reg;
            sum_vld_reg  <= pair_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg      <= sq_next;
            sqv_reg     <= nrm_vec[NSH];
            pair_reg[0] <= rmq_pkg::PAIR_W'(sq_reg[0]) + rmq_pkg::PAIR_W'(sq_reg[1]);
            pair_reg[1] <= rmq_pkg::PAIR_W'(sq_reg[2]) + rmq_pkg::PAIR_W'(sq_reg[3]);
            pairv_reg   <= sqv_reg;
            sum_reg     <= rmq_pkg::SUM_W'(pair_reg[0]) + rmq_pkg::SUM_W'(pair_reg[1]);
            sumv_reg    <= pairv_reg;
        end
    end

    // ------------------------------------------------------ square root row
    logic                         sr_vld  [NSQ+1];
    logic [rmq_pkg::SUM_W-1:0]    sr_rad  [NSQ+1];
    logic [rmq_pkg::REM_W-1:0]    sr_rem  [NSQ+1];
    logic [rmq_pkg::ROOT_W-1:0]   sr_root [NSQ+1];
    rmq_pkg::rmq_vec_t            sr_vec  [NSQ+1];

    assign sr_vld[0]  = sum_vld_reg;
    assign sr_rad[0]  = sum_reg;
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;
    assign sr_vec[0]  = sumv_reg;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sr_vld[g]),
            .in_rad   (sr_rad[g]),
            .in_rem   (sr_rem[g]),
            .in_root  (sr_root[g]),
            .in_vec   (sr_vec[g]),
            .out_valid(sr_vld[g+1]),
            .out_rad  (sr_rad[g+1]),
            .out_rem  (sr_rem[g+1]),
            .out_root (sr_root[g+1]),
            .out_vec  (sr_vec[g+1])
        );
    end

    // --------------------------------------------- dividend set-up (round)
    // dividend = mag * 2^F + floor(N / 2); quotient fits F+1 bits since mag <= N
    logic [NAX-1:0][DW-1:0] dvd;

    always_comb begin
        for (int c = 0; c < NAX; c++) begin
            dvd[c] = (DW'(sr_vec[NSQ].mag[c]) << FRACTION_BITS)
                   + DW'(sr_root[NSQ][rmq_pkg::ROOT_W-1:1]);
        end
    end

    logic                                          dv_vld [NDV+1];
    logic [NAX-1:0][rmq_pkg::ROOT_W-1:0]           dv_rem [NDV+1];
    logic [NAX-1:0][FRACTION_BITS:0]               dv_low [NDV+1];
    logic [rmq_pkg::ROOT_W-1:0]                    dv_nrm [NDV+1];
    rmq_pkg::rmq_tag_t                             dv_tag [NDV+1];

    logic                                          prep_vld_reg;
    logic [NAX-1:0][rmq_pkg::ROOT_W-1:0]           prep_rem_reg;
    logic [NAX-1:0][FRACTION_BITS:0]               prep_low_reg;
    logic [rmq_pkg::ROOT_W-1:0]                    prep_nrm_reg;
    rmq_pkg::rmq_tag_t                             prep_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (en) begin
            prep_vld_reg <= sr_vld[NSQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NAX; c++) begin
                prep_rem_reg[c] <= rmq_pkg::ROOT_W'(dvd[c][DW-1:FRACTION_BITS+1]);
                prep_low_reg[c] <= dvd[c][FRACTION_BITS:0];
            end
            prep_nrm_reg     <= sr_root[NSQ];
            prep_tag_reg.neg <= sr_vec[NSQ].tag.neg;
            prep_tag_reg.bad <= sr_vec[NSQ].tag.bad || (sr_root[NSQ] == '0);
        end
    end

    assign dv_vld[0] = prep_vld_reg;
    assign dv_rem[0] = prep_rem_reg;
    assign dv_low[0] = prep_low_reg;
    assign dv_nrm[0] = prep_nrm_reg;
    assign dv_tag[0] = prep_tag_reg;

    // ---------------------------------------------------------- divider row
    for (genvar g = 0; g < NDV; g++) begin : g_div
        rmq_div_cell #(
            .FRACTION_BITS(FRACTION_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dv_vld[g]),
            .in_rem   (dv_rem[g]),
            .in_low   (dv_low[g]),
            .in_nrm   (dv_nrm[g]),
            .in_tag   (dv_tag[g]),
            .out_valid(dv_vld[g+1]),
            .out_rem  (dv_rem[g+1]),
            .out_low  (dv_low[g+1]),
            .out_nrm  (dv_nrm[g+1]),
            .out_tag  (dv_tag[g+1])
        );
    end

    // ------------------------------------------- sign, saturate, output word
    logic [rmq_pkg::ROOT_W-1:0] qz  [NAX];
    logic [rmq_pkg::ROOT_W-1:0] qn  [NAX];
    logic [NAX-1:0][QW-1:0]     quat_next, quat_reg;
    logic                       bad_next, bad_reg, out_vld_reg;

    always_comb begin
        bad_next = dv_tag[NDV].bad;
        for (int c = 0; c < NAX; c++) begin
            qz[c] = rmq_pkg::ROOT_W'(dv_low[NDV][c]);
            qn[c] = -qz[c];
            if (dv_tag[NDV].neg[c]) begin
                quat_next[c] = (qz[c] > rmq_pkg::QUAT_NEG_MAX)
                             ? rmq_pkg::QUAT_SAT_LO : qn[c][QW-1:0];
            end else begin
                quat_next[c] = (qz[c] > rmq_pkg::QUAT_POS_MAX)
                             ? rmq_pkg::QUAT_SAT_HI : qz[c][QW-1:0];
            end
        end
        if (bad_next) begin
            quat_next[0] = ID_W;
            quat_next[1] = '0;
            quat_next[2] = '0;
            quat_next[3] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld[NDV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quat_reg <= quat_next;
            bad_reg  <= bad_next;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = quat_reg;
    assign m_tuser[0] = bad_reg;

    // ------------------------------------------------------------ assertions
    // a flagged word carries the identity quaternion
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[71:18] == '0 && m_tdata[17:0] == ID_W)
        else $error("flagged word is not the identity quaternion");

    // in the cycle after reset no word is shown
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    // a stalled result blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // a stalled result is held into the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

`default_nettype wire

>>> tb/tb_rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives 3x3 rotation matrices into the quaternion pipeline and checks each
// quaternion word against an in-bench Shepperd conversion, in order.
// ----------------------------------------------------------------------------
`default_nettype none

class quat_scoreboard;
    typedef struct packed {
        logic [17:0] w, x, y, z;
        logic        bad;
    } quat_t;

    quat_t pending_quats[$];
    int    errors;

    function new();
        errors = 0;
    endfunction

    static function longint isqrt(longint unsigned s);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > s) bt >>= 2;
        while (bt != 0) begin
            if (s >= res + bt) begin
                s -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    static function logic [17:0] clamp18(longint v);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[17:0];
    endfunction

    // Shepperd conversion of one matrix word
    function void note_matrix(logic [167:0] word);
        longint m[3][3];
        longint v[4];
        longint unsigned mag[4], mx, sum, nrm, q;
        longint tr, a, s;
        longint one;
        int i, j, k, sh;
        quat_t e;
        one = 64'sd1 << 16;
        for (int n = 0; n < 9; n++)
            m[n / 3][n % 3] = longint'($signed(word[n*18 +: 18]));
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            a = tr + one;
            v[0] = a;
            v[1] = m[1][2] - m[2][1];
            v[2] = m[2][0] - m[0][2];
            v[3] = m[0][1] - m[1][0];
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            a = m[i][i] - (m[j][j] + m[k][k]) + one;
            v[0] = m[j][k] - m[k][j];
            v[1+i] = a;
            v[1+j] = m[i][j] + m[j][i];
            v[1+k] = m[i][k] + m[k][i];
        end
        e = '{w: clamp18(one), x: 0, y: 0, z: 0, bad: 1'b1};
        if (a > 0) begin
            mx = 0;
            for (int c = 0; c < 4; c++) begin
                mag[c] = (v[c] < 0) ? -v[c] : v[c];
                if (mag[c] > mx) mx = mag[c];
            end
            sh = 0;
            while (mx != 0 && mx < (64'd1 << 30)) begin
                mx <<= 1;
                sh++;
            end
            sum = 0;
            for (int c = 0; c < 4; c++) begin
                mag[c] <<= sh;
                sum += mag[c] * mag[c];
            end
            nrm = isqrt(sum);
            if (nrm != 0) begin
                for (int c = 0; c < 4; c++) begin
                    q = ((mag[c] << 16) + (nrm >> 1)) / nrm;
                    s = (v[c] < 0) ? -longint'(q) : longint'(q);
                    case (c)
                        0: e.w = clamp18(s);
                        1: e.x = clamp18(s);
                        2: e.y = clamp18(s);
                        default: e.z = clamp18(s);
                    endcase
                end
                e.bad = 1'b0;
            end
        end
        pending_quats.push_back(e);
    endfunction

    function void check_quat(logic [71:0] data, logic bad);
        quat_t got, e;
        got = {data[17:0], data[35:18], data[53:36], data[71:54], bad};
        if (pending_quats.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, got);
            errors++;
            return;
        end
        e = pending_quats.pop_front();
        if (got.w !== e.w) begin
            $display("%0t: w expected %h actual %h", $time, e.w, got.w);
            errors++;
        end
        if (got.x !== e.x) begin
            $display("%0t: x expected %h actual %h", $time, e.x, got.x);
            errors++;
        end
        if (got.y !== e.y) begin
            $display("%0t: y expected %h actual %h", $time, e.y, got.y);
            errors++;
        end
        if (got.z !== e.z) begin
            $display("%0t: z expected %h actual %h", $time, e.z, got.z);
            errors++;
        end
        if (got.bad !== e.bad) begin
            $display("%0t: bad_input expected %b actual %b", $time, e.bad, got.bad);
            errors++;
        end
    endfunction
endclass

module tb_rotation_matrix_to_quaternion;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT = 61;
    localparam int ONE      = 65536; // one unit in Q2.16

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [0:0]   m_tuser;

    int send_idle_pct;   // sender gap chance, percent
    int recv_stall_pct;  // receiver stall chance, percent

    quat_scoreboard quat_sb = new();

    rotation_matrix_to_quaternion DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // result side: random stalls, check every accepted word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            quat_sb.check_quat(m_tdata, m_tuser[0]);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one matrix word; idle gaps first, then hold until accepted
    task automatic send_matrix(input logic [17:0] e[9]);
        logic [167:0] w;
        w = '0;
        for (int n = 0; n < 9; n++) w[n*18 +: 18] = e[n];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        quat_sb.note_matrix(w);
    endtask

    task automatic send_diag(input int d0, input int d1, input int d2,
                             input int off);
        logic [17:0] e[9];
        for (int n = 0; n < 9; n++) e[n] = 18'(off * (n - 4));
        e[0] = 18'(d0);
        e[4] = 18'(d1);
        e[8] = 18'(d2);
        send_matrix(e);
    endtask

    task automatic send_fill(input logic [17:0] val);
        logic [17:0] e[9];
        for (int n = 0; n < 9; n++) e[n] = val;
        send_matrix(e);
    endtask

    // near-rotation: diag dominant with small random off-diagonals, or all random when wild
    task automatic send_random(input bit wild);
        logic [17:0] e[9];
        for (int n = 0; n < 9; n++) begin
            if (wild)
                e[n] = 18'($urandom);
            else if (n % 4 == 0)
                e[n] = 18'($urandom_range(2 * ONE) - ONE);
            else
                e[n] = 18'($urandom_range(ONE) - ONE / 2);
        end
        send_matrix(e);
    endtask

    task automatic drain_quats();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (quat_sb.pending_quats.size() != 0) @(posedge aclk);
    endtask

    initial begin
        send_idle_pct  = 31;
        recv_stall_pct = 51;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, each pivot, ties, field extremes
        send_diag(ONE, ONE, ONE, 0);
        send_diag(ONE, -ONE, -ONE, 0);     // x pivot
        send_diag(-ONE, ONE, -ONE, 0);     // y pivot
        send_diag(-ONE, -ONE, ONE, 0);     // z pivot
        send_diag(0, 0, 0, 0);             // zero trace, tie on all
        send_diag(-ONE, -ONE, -ONE, 0);    // tie, negative
        send_diag(-ONE, ONE / 2, ONE / 2, 1000);
        send_diag(ONE / 2, -ONE, ONE / 2, -700);
        send_diag(-ONE / 4, -ONE / 2, -ONE / 2, 0); // negative trace, x pivot
        send_diag(-131072, -131072, 131071, 0);
        send_diag(ONE, ONE, -ONE, 20000);
        send_fill(18'h1FFFF);
        send_fill(18'h20000);
        send_fill(18'h3FFFF);
        send_fill(18'h00000);
        send_fill(18'h2AAAA);
        send_fill(18'h15555);
        send_diag(-2, 1, 1, 3);
        send_diag(1, 1, -2, -3);
        drain_quats();             // sender pauses until all results are in

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 31 : (ph == 1) ? 51 : 0;
            recv_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 31 : 0;
            for (int n = 0; n < 630; n++)
                send_random($urandom_range(3) == 0);
        end
        drain_quats();
        repeat (PIPE_LAT) @(posedge aclk);

        if (quat_sb.errors == 0)
            $display("tb_rotation_matrix_to_quaternion: done, clean");
        else
            $display("tb_rotation_matrix_to_quaternion: done, errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_rotation_matrix_to_quaternion: done, errors");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_norm_cell.sv
design/rmq_sqrt_cell.sv
design/rmq_div_cell.sv
design/rotation_matrix_to_quaternion.sv
tb/tb_rotation_matrix_to_quaternion.sv
